[hdl/sm4_pkg.sv]
// ----------------------------------------------------------------------------
// sm4_pkg
// Shared constants and round functions for the SM4 cipher pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package sm4_pkg;

  localparam int unsigned NUM_ROUNDS = 32;
  localparam int unsigned RK_IDX_W   = 5;

  localparam logic [31:0] FK0 = 32'ha3b1bac6;
  localparam logic [31:0] FK1 = 32'h56aa3350;
  localparam logic [31:0] FK2 = 32'h677d9197;
  localparam logic [31:0] FK3 = 32'hb27022dc;

  localparam logic [0:0] REQ_ENCRYPT = 1'b0;
  localparam logic [0:0] REQ_DECRYPT = 1'b1;

  localparam logic [0:0] REG_KEY_HIGH = 1'b0;
  localparam logic [0:0] REG_KEY_LOW  = 1'b1;

  typedef logic [31:0] word_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] r;
    case (a)
      8'h00: r=8'hd6; 8'h01: r=8'h90; 8'h02: r=8'he9; 8'h03: r=8'hfe;
      8'h04: r=8'hcc; 8'h05: r=8'he1; 8'h06: r=8'h3d; 8'h07: r=8'hb7;
      8'h08: r=8'h16; 8'h09: r=8'hb6; 8'h0a: r=8'h14; 8'h0b: r=8'hc2;
      8'h0c: r=8'h28; 8'h0d: r=8'hfb; 8'h0e: r=8'h2c; 8'h0f: r=8'h05;
      8'h10: r=8'h2b; 8'h11: r=8'h67; 8'h12: r=8'h9a; 8'h13: r=8'h76;
      8'h14: r=8'h2a; 8'h15: r=8'hbe; 8'h16: r=8'h04; 8'h17: r=8'hc3;
      8'h18: r=8'haa; 8'h19: r=8'h44; 8'h1a: r=8'h13; 8'h1b: r=8'h26;
      8'h1c: r=8'h49; 8'h1d: r=8'h86; 8'h1e: r=8'h06; 8'h1f: r=8'h99;
      8'h20: r=8'h9c; 8'h21: r=8'h42; 8'h22: r=8'h50; 8'h23: r=8'hf4;
      8'h24: r=8'h91; 8'h25: r=8'hef; 8'h26: r=8'h98; 8'h27: r=8'h7a;
      8'h28: r=8'h33; 8'h29: r=8'h54; 8'h2a: r=8'h0b; 8'h2b: r=8'h43;
      8'h2c: r=8'hed; 8'h2d: r=8'hcf; 8'h2e: r=8'hac; 8'h2f: r=8'h62;
      8'h30: r=8'he4; 8'h31: r=8'hb3; 8'h32: r=8'h1c; 8'h33: r=8'ha9;
      8'h34: r=8'hc9; 8'h35: r=8'h08; 8'h36: r=8'he8; 8'h37: r=8'h95;
      8'h38: r=8'h80; 8'h39: r=8'hdf; 8'h3a: r=8'h94; 8'h3b: r=8'hfa;
      8'h3c: r=8'h75; 8'h3d: r=8'h8f; 8'h3e: r=8'h3f; 8'h3f: r=8'ha6;
      8'h40: r=8'h47; 8'h41: r=8'h07; 8'h42: r=8'ha7; 8'h43: r=8'hfc;
      8'h44: r=8'hf3; 8'h45: r=8'h73; 8'h46: r=8'h17; 8'h47: r=8'hba;
      8'h48: r=8'h83; 8'h49: r=8'h59; 8'h4a: r=8'h3c; 8'h4b: r=8'h19;
      8'h4c: r=8'he6; 8'h4d: r=8'h85; 8'h4e: r=8'h4f; 8'h4f: r=8'ha8;
      8'h50: r=8'h68; 8'h51: r=8'h6b; 8'h52: r=8'h81; 8'h53: r=8'hb2;
      8'h54: r=8'h71; 8'h55: r=8'h64; 8'h56: r=8'hda; 8'h57: r=8'h8b;
      8'h58: r=8'hf8; 8'h59: r=8'heb; 8'h5a: r=8'h0f; 8'h5b: r=8'h4b;
      8'h5c: r=8'h70; 8'h5d: r=8'h56; 8'h5e: r=8'h9d; 8'h5f: r=8'h35;
      8'h60: r=8'h1e; 8'h61: r=8'h24; 8'h62: r=8'h0e; 8'h63: r=8'h5e;
      8'h64: r=8'h63; 8'h65: r=8'h58; 8'h66: r=8'hd1; 8'h67: r=8'ha2;
      8'h68: r=8'h25; 8'h69: r=8'h22; 8'h6a: r=8'h7c; 8'h6b: r=8'h3b;
      8'h6c: r=8'h01; 8'h6d: r=8'h21; 8'h6e: r=8'h78; 8'h6f: r=8'h87;
      8'h70: r=8'hd4; 8'h71: r=8'h00; 8'h72: r=8'h46; 8'h73: r=8'h57;
      8'h74: r=8'h9f; 8'h75: r=8'hd3; 8'h76: r=8'h27; 8'h77: r=8'h52;
      8'h78: r=8'h4c; 8'h79: r=8'h36; 8'h7a: r=8'h02; 8'h7b: r=8'he7;
      8'h7c: r=8'ha0; 8'h7d: r=8'hc4; 8'h7e: r=8'hc8; 8'h7f: r=8'h9e;
      8'h80: r=8'hea; 8'h81: r=8'hbf; 8'h82: r=8'h8a; 8'h83: r=8'hd2;
      8'h84: r=8'h40; 8'h85: r=8'hc7; 8'h86: r=8'h38; 8'h87: r=8'hb5;
      8'h88: r=8'ha3; 8'h89: r=8'hf7; 8'h8a: r=8'hf2; 8'h8b: r=8'hce;
      8'h8c: r=8'hf9; 8'h8d: r=8'h61; 8'h8e: r=8'h15; 8'h8f: r=8'ha1;
      8'h90: r=8'he0; 8'h91: r=8'hae; 8'h92: r=8'h5d; 8'h93: r=8'ha4;
      8'h94: r=8'h9b; 8'h95: r=8'h34; 8'h96: r=8'h1a; 8'h97: r=8'h55;
      8'h98: r=8'had; 8'h99: r=8'h93; 8'h9a: r=8'h32; 8'h9b: r=8'h30;
      8'h9c: r=8'hf5; 8'h9d: r=8'h8c; 8'h9e: r=8'hb1; 8'h9f: r=8'he3;
      8'ha0: r=8'h1d; 8'ha1: r=8'hf6; 8'ha2: r=8'he2; 8'ha3: r=8'h2e;
      8'ha4: r=8'h82; 8'ha5: r=8'h66; 8'ha6: r=8'hca; 8'ha7: r=8'h60;
      8'ha8: r=8'hc0; 8'ha9: r=8'h29; 8'haa: r=8'h23; 8'hab: r=8'hab;
      8'hac: r=8'h0d; 8'had: r=8'h53; 8'hae: r=8'h4e; 8'haf: r=8'h6f;
      8'hb0: r=8'hd5; 8'hb1: r=8'hdb; 8'hb2: r=8'h37; 8'hb3: r=8'h45;
      8'hb4: r=8'hde; 8'hb5: r=8'hfd; 8'hb6: r=8'h8e; 8'hb7: r=8'h2f;
      8'hb8: r=8'h03; 8'hb9: r=8'hff; 8'hba: r=8'h6a; 8'hbb: r=8'h72;
      8'hbc: r=8'h6d; 8'hbd: r=8'h6c; 8'hbe: r=8'h5b; 8'hbf: r=8'h51;
      8'hc0: r=8'h8d; 8'hc1: r=8'h1b; 8'hc2: r=8'haf; 8'hc3: r=8'h92;
      8'hc4: r=8'hbb; 8'hc5: r=8'hdd; 8'hc6: r=8'hbc; 8'hc7: r=8'h7f;
      8'hc8: r=8'h11; 8'hc9: r=8'hd9; 8'hca: r=8'h5c; 8'hcb: r=8'h41;
      8'hcc: r=8'h1f; 8'hcd: r=8'h10; 8'hce: r=8'h5a; 8'hcf: r=8'hd8;
      8'hd0: r=8'h0a; 8'hd1: r=8'hc1; 8'hd2: r=8'h31; 8'hd3: r=8'h88;
      8'hd4: r=8'ha5; 8'hd5: r=8'hcd; 8'hd6: r=8'h7b; 8'hd7: r=8'hbd;
      8'hd8: r=8'h2d; 8'hd9: r=8'h74; 8'hda: r=8'hd0; 8'hdb: r=8'h12;
      8'hdc: r=8'hb8; 8'hdd: r=8'he5; 8'hde: r=8'hb4; 8'hdf: r=8'hb0;
      8'he0: r=8'h89; 8'he1: r=8'h69; 8'he2: r=8'h97; 8'he3: r=8'h4a;
      8'he4: r=8'h0c; 8'he5: r=8'h96; 8'he6: r=8'h77; 8'he7: r=8'h7e;
      8'he8: r=8'h65; 8'he9: r=8'hb9; 8'hea: r=8'hf1; 8'heb: r=8'h09;
      8'hec: r=8'hc5; 8'hed: r=8'h6e; 8'hee: r=8'hc6; 8'hef: r=8'h84;
      8'hf0: r=8'h18; 8'hf1: r=8'hf0; 8'hf2: r=8'h7d; 8'hf3: r=8'hec;
      8'hf4: r=8'h3a; 8'hf5: r=8'hdc; 8'hf6: r=8'h4d; 8'hf7: r=8'h20;
      8'hf8: r=8'h79; 8'hf9: r=8'hee; 8'hfa: r=8'h5f; 8'hfb: r=8'h3e;
      8'hfc: r=8'hd7; 8'hfd: r=8'hcb; 8'hfe: r=8'h39; 8'hff: r=8'h48;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic word_t subst_word(input word_t v);
    return {sbox(v[31:24]), sbox(v[23:16]), sbox(v[15:8]), sbox(v[7:0])};
  endfunction

  function automatic word_t rotl(input word_t v, input int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic word_t key_mix(input word_t v);
    word_t a;
    a = subst_word(v);
    return a ^ rotl(a, 13) ^ rotl(a, 23);
  endfunction

  function automatic word_t data_mix(input word_t v);
    word_t a;
    a = subst_word(v);
    return a ^ rotl(a, 2) ^ rotl(a, 10) ^ rotl(a, 18) ^ rotl(a, 24);
  endfunction

  // CK word i: byte j, most significant first, is (4i+j)*7 mod 256
  function automatic word_t ck_word(input logic [RK_IDX_W-1:0] i);
    logic [7:0] b0, b1, b2, b3;
    logic [7:0] base;
    base = {1'b0, i, 2'b00};
    b0 = 8'((base + 8'd0) * 8'd7);
    b1 = 8'((base + 8'd1) * 8'd7);
    b2 = 8'((base + 8'd2) * 8'd7);
    b3 = 8'((base + 8'd3) * 8'd7);
    return {b0, b1, b2, b3};
  endfunction

endpackage
`default_nettype wire

[hdl/sm4_key_sched.sv]
// ----------------------------------------------------------------------------
// sm4_key_sched
// Expands the round keys one per cycle into a register file after a key write.
// ----------------------------------------------------------------------------
`default_nettype none
module sm4_key_sched (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [127:0]         key,
  output logic                      ready,
  output sm4_pkg::word_t [31:0]     rk
);
  import sm4_pkg::*;

  logic                busy_r;
  logic                ready_r;
  logic [RK_IDX_W-1:0] idx_r;
  word_t               k_r [4];
  word_t               rk_r [NUM_ROUNDS];
  word_t               nk;

  assign nk = k_r[0] ^ key_mix(k_r[1] ^ k_r[2] ^ k_r[3] ^ ck_word(idx_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      ready_r <= 1'b0;
      idx_r   <= '0;
    end else if (start) begin
      busy_r  <= 1'b1;
      ready_r <= 1'b0;
      idx_r   <= '0;
    end else if (busy_r) begin
      idx_r <= idx_r + 1'b1;
      if (idx_r == RK_IDX_W'(NUM_ROUNDS - 1)) begin
        busy_r  <= 1'b0;
        ready_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      k_r[0] <= key[31:0]   ^ FK0;
      k_r[1] <= key[63:32]  ^ FK1;
      k_r[2] <= key[95:64]  ^ FK2;
      k_r[3] <= key[127:96] ^ FK3;
    end else if (busy_r) begin
      k_r[0] <= k_r[1];
      k_r[1] <= k_r[2];
      k_r[2] <= k_r[3];
      k_r[3] <= nk;
      rk_r[idx_r] <= nk;
    end
  end

  assign ready = ready_r;
  always_comb begin
    for (int i = 0; i < NUM_ROUNDS; i++) rk[i] = rk_r[i];
  end
endmodule
`default_nettype wire

[hdl/sm4_round.sv]
// ----------------------------------------------------------------------------
// sm4_round
// One registered cipher round stage with stall handling.
// ----------------------------------------------------------------------------
`default_nettype none
module sm4_round (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            adv,
  input  wire logic            in_v,
  input  wire logic [127:0]    in_x,
  input  wire logic            in_dec,
  input  sm4_pkg::word_t       rk_enc,
  input  sm4_pkg::word_t       rk_dec,
  output logic                 out_v,
  output logic [127:0]         out_x,
  output logic                 out_dec
);
  import sm4_pkg::*;

  logic         v_r;
  logic [127:0] x_r;
  logic         dec_r;
  word_t        rk, nx;

  assign rk = in_dec ? rk_dec : rk_enc;
  assign nx = in_x[31:0] ^ data_mix(in_x[63:32] ^ in_x[95:64] ^ in_x[127:96] ^ rk);

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= 1'b0;
    else if (adv) v_r <= in_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r   <= {nx, in_x[127:32]};
      dec_r <= in_dec;
    end
  end

  assign out_v   = v_r;
  assign out_x   = x_r;
  assign out_dec = dec_r;
endmodule
`default_nettype wire

[hdl/sm4_block_cipher.sv]
// ----------------------------------------------------------------------------
// sm4_block_cipher
// SM4 encrypt/decrypt engine: 32 unrolled round stages, one block per cycle when not stalled.
// ----------------------------------------------------------------------------
// channel   | dir | handshake           | payload
// in_       | in  | tvalid/tready       | tdata = block_low, block_high; tuser = req_type
// out_      | out | tvalid/tready       | tdata = result_low, result_high
// cfg_      | in  | wr_en, no wait      | idx 0 key_high, idx 1 key_low
// Each block moves through the round registers in order; throughput is one block a
// cycle while out_ is not stalled. A key write starts an expansion of one round key
// a cycle; in_tready stays low until the keys are ready. Reset is synchronous, active low.
// A stall at out_ freezes the whole round pipeline; nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none
module sm4_block_cipher (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [127:0] in_tdata,   // block_low, block_high
  input  wire logic         in_tuser,   // req_type
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [127:0]      out_tdata,  // result_low, result_high
  input  wire logic         cfg_wr_en,
  input  wire logic         cfg_index,
  input  wire logic [63:0]  cfg_wdata
);
  import sm4_pkg::*;

  logic [63:0] key_high_r, key_low_r;
  logic        stale_r;
  logic        ks_start, ks_ready;
  word_t [31:0] rk;
  logic        adv;

  logic         v   [NUM_ROUNDS+1];
  logic [127:0] x   [NUM_ROUNDS+1];
  logic         dec [NUM_ROUNDS+1];

  // key registers; a write marks the expanded keys stale
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
      stale_r    <= 1'b1;
    end else if (cfg_wr_en) begin
      stale_r <= 1'b1;
      case (cfg_index)
        REG_KEY_HIGH: key_high_r <= cfg_wdata;
        REG_KEY_LOW:  key_low_r  <= cfg_wdata;
        default: ;
      endcase
    end else if (stale_r) begin
      stale_r <= 1'b0;
    end
  end

  assign ks_start = stale_r && !cfg_wr_en;

  sm4_key_sched u_ks (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ks_start),
    .key   ({key_high_r, key_low_r}),
    .ready (ks_ready),
    .rk    (rk)
  );

  // pipeline advances unless the final stage holds a result not taken
  assign adv       = !v[NUM_ROUNDS] || out_tready;
  assign in_tready = adv && ks_ready && !stale_r;

  // round state holds word 0 in the low bits: {block_high, block_low}
  assign v[0]   = in_tvalid && in_tready;
  assign x[0]   = {in_tdata[63:0], in_tdata[127:64]};
  assign dec[0] = in_tuser;

  for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_rnd
    sm4_round u_rnd (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .in_v    (v[g]),
      .in_x    (x[g]),
      .in_dec  (dec[g]),
      .rk_enc  (rk[g]),
      .rk_dec  (rk[NUM_ROUNDS-1-g]),
      .out_v   (v[g+1]),
      .out_x   (x[g+1]),
      .out_dec (dec[g+1])
    );
  end

  // result_high = words 32, 33 in the low half; result_low = words 34, 35 above
  assign out_tvalid = v[NUM_ROUNDS];
  assign out_tdata  = {x[NUM_ROUNDS][95:64], x[NUM_ROUNDS][127:96],
                       x[NUM_ROUNDS][31:0],  x[NUM_ROUNDS][63:32]};

  logic unused_dec;
  assign unused_dec = dec[NUM_ROUNDS];
endmodule
`default_nettype wire

[verif/tb_sm4_block_cipher.sv]
// ----------------------------------------------------------------------------
// tb_sm4_block_cipher
// Self-checking bench for the SM4 engine: directed blocks, key changes and
// random traffic with random stalls on both sides, checked against an
// in-bench cipher model.
// ----------------------------------------------------------------------------
module tb_sm4_block_cipher;
  timeunit 1ns;
  timeprecision 1ps;
  import sm4_pkg::*;

  // Item as it travels on the bus
  typedef struct packed {
    logic        req_type;
    logic [63:0] block_high;
    logic [63:0] block_low;
  } block_item_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;    // block_low, block_high
  logic         in_tuser;    // req_type
  logic         out_tvalid;
  logic         out_tready;
  logic [127:0] out_tdata;   // result_low, result_high
  logic         cfg_wr_en;
  logic         cfg_index;
  logic [63:0]  cfg_wdata;

  sm4_block_cipher dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Bench-side model state
  logic [63:0]  model_key_high, model_key_low;
  logic [31:0]  model_round_keys [32];
  bit           model_keys_valid;
  logic [127:0] expected_blocks [$];
  int           error_count;
  bit           hold_off;       // long receiver stall requested
  int           hold_off_cycles;

  localparam logic [7:0] SBOX_TABLE [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  function automatic logic [31:0] tau(input logic [31:0] v);
    return {SBOX_TABLE[v[31:24]], SBOX_TABLE[v[23:16]],
            SBOX_TABLE[v[15:8]], SBOX_TABLE[v[7:0]]};
  endfunction

  function automatic logic [31:0] rol(input logic [31:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  // Key schedule: FK whitening, CK chain, T' linear map (13, 23)
  task automatic build_round_keys();
    logic [31:0] k [4];
    logic [31:0] a, ck, nk;
    k[0] = model_key_low[31:0]   ^ FK0;
    k[1] = model_key_low[63:32]  ^ FK1;
    k[2] = model_key_high[31:0]  ^ FK2;
    k[3] = model_key_high[63:32] ^ FK3;
    for (int i = 0; i < 32; i++) begin
      ck = '0;
      for (int j = 0; j < 4; j++) ck = {ck[23:0], 8'(((4 * i + j) * 7) % 256)};
      a = tau(k[1] ^ k[2] ^ k[3] ^ ck);
      nk = k[0] ^ a ^ rol(a, 13) ^ rol(a, 23);
      model_round_keys[i] = nk;
      k[0] = k[1]; k[1] = k[2]; k[2] = k[3]; k[3] = nk;
    end
    model_keys_valid = 1'b1;
  endtask

  // 32 data rounds; decrypt walks the round keys backwards, output reversed
  task automatic cipher_block(input block_item_t it, output logic [127:0] res);
    logic [31:0] x [4];
    logic [31:0] a, rk, nx;
    if (!model_keys_valid) build_round_keys();
    x[0] = it.block_low[31:0];  x[1] = it.block_low[63:32];
    x[2] = it.block_high[31:0]; x[3] = it.block_high[63:32];
    for (int i = 0; i < 32; i++) begin
      rk = model_round_keys[(it.req_type == REQ_DECRYPT) ? 31 - i : i];
      a = tau(x[1] ^ x[2] ^ x[3] ^ rk);
      nx = x[0] ^ a ^ rol(a, 2) ^ rol(a, 10) ^ rol(a, 18) ^ rol(a, 24);
      x[0] = x[1]; x[1] = x[2]; x[2] = x[3]; x[3] = nx;
    end
    res = {x[0], x[1], x[2], x[3]};   // result_high in 127:64, result_low in 63:0
  endtask

  function automatic int pick_gap();
    // mostly back-to-back or short, now and then long
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  int gap_mode;   // 0 random gaps, 1 no gaps

  // Send one block; model is updated at the accepting edge. in_tvalid stays
  // up on return so a following item can go out back to back.
  task automatic send_block(input block_item_t it);
    logic [127:0] res;
    int gap;
    gap = (gap_mode == 1) ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {it.block_low, it.block_high};
    in_tuser  <= it.req_type;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    cipher_block(it, res);
    expected_blocks.push_back(res);
    @(negedge clk);
  endtask

  // Only when idle: wait for drain plus pipeline depth before touching keys
  task automatic write_key(input logic [63:0] hi, input logic [63:0] lo);
    in_tvalid <= 1'b0;
    while (expected_blocks.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    cfg_wr_en <= 1'b1; cfg_index <= REG_KEY_HIGH; cfg_wdata <= hi;
    @(negedge clk);
    cfg_index <= REG_KEY_LOW; cfg_wdata <= lo;
    @(negedge clk);
    cfg_wr_en <= 1'b0; cfg_wdata <= '0;
    model_key_high = hi; model_key_low = lo; model_keys_valid = 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic block_item_t rand_item();
    block_item_t it;
    it.req_type = 1'($urandom_range(0, 1));
    it.block_high = rand64();
    it.block_low  = rand64();
    case ($urandom_range(0, 9))
      0: it.block_high = '0;
      1: it.block_low  = '1;
      default: ;
    endcase
    return it;
  endfunction

  // Receiver: random readiness, optional long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_tready <= 1'b0;
    end else if (hold_off) begin
      hold_off <= 1'b0;
      hold_off_cycles <= 200;
      out_tready <= 1'b0;
    end else if (gap_mode == 1) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= (pick_gap() == 0) || ($urandom_range(0, 1) == 1);
    end
  end

  // Result check against the oldest expectation
  always @(posedge clk) begin
    logic [127:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_blocks.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, out_tdata);
        error_count++;
      end else begin
        want = expected_blocks.pop_front();
        if (out_tdata[63:0] !== want[127:64]) begin
          $display("%0t: result_high expected %h actual %h", $realtime,
                   want[127:64], out_tdata[63:0]);
          error_count++;
        end
        if (out_tdata[127:64] !== want[63:0]) begin
          $display("%0t: result_low expected %h actual %h", $realtime,
                   want[63:0], out_tdata[127:64]);
          error_count++;
        end
      end
    end
  end

  // Standard vector, zero key first, all-ones extremes, both directions
  task automatic test_directed();
    block_item_t it;
    it = '{REQ_ENCRYPT, 64'h0, 64'h0};           send_block(it); // key never written
    write_key(64'h0123456789abcdef, 64'hfedcba9876543210);
    it = '{REQ_ENCRYPT, 64'h0123456789abcdef, 64'hfedcba9876543210}; send_block(it);
    it = '{REQ_DECRYPT, 64'h681edf34d206965e, 64'h86b3e94f536e4246}; send_block(it);
    it = '{REQ_ENCRYPT, '1, '1};                  send_block(it);
    it = '{REQ_DECRYPT, '1, '1};                  send_block(it);
    it = '{REQ_DECRYPT, '0, '0};                  send_block(it);
    it = '{REQ_ENCRYPT, 64'h8000000000000000, 64'h1}; send_block(it);
    write_key('1, '1);
    it = '{REQ_ENCRYPT, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555}; send_block(it);
    it = '{REQ_DECRYPT, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa}; send_block(it);
    write_key('0, '0);
    it = '{REQ_ENCRYPT, '1, '0};                  send_block(it);
    it = '{REQ_DECRYPT, '0, '1};                  send_block(it);
  endtask

  // Receiver stalls long while the sender streams, so in_tready must drop
  task automatic test_backpressure();
    gap_mode = 1;
    hold_off = 1'b1;
    repeat (60) send_block(rand_item());
    gap_mode = 0;
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 6; phase++) begin
      write_key(rand64(), rand64());
      gap_mode = (phase == 2) ? 1 : 0;
      repeat (210) send_block(rand_item());
    end
    gap_mode = 0;
  endtask

  initial begin
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0; in_tuser = 1'b0;
    cfg_wr_en = 1'b0; cfg_index = 1'b0; cfg_wdata = '0;
    hold_off = 1'b0; hold_off_cycles = 0; gap_mode = 0; error_count = 0;
    model_key_high = '0; model_key_low = '0; model_keys_valid = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_backpressure();
    test_random();
    in_tvalid <= 1'b0;
    while (expected_blocks.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (error_count == 0 && expected_blocks.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end
endmodule

[filelist.f]
hdl/sm4_pkg.sv
hdl/sm4_key_sched.sv
hdl/sm4_round.sv
hdl/sm4_block_cipher.sv
verif/tb_sm4_block_cipher.sv
